[rtl/accel_fifo_frame_parser_top_defines.svh]
// Assertion macros for the accelerometer FIFO frame parser.
// Depends on nothing; included by the top level.
`ifndef ACCEL_FIFO_FRAME_PARSER_TOP_DEFINES_SVH
`define ACCEL_FIFO_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset
`define AFP_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every edge, reset included
`define AFP_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define AFP_ASSERT(label, clock, reset, prop, msg)
`define AFP_ASSERT_ALWAYS(label, clock, prop, msg)
`endif

`endif

[rtl/afp_pkg.sv]
// Shared types, constants and helpers for the accelerometer FIFO frame parser.
// No dependencies.
package afp_pkg;

  // Frame parser state codes
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ACCEL  = 2'd1;
  localparam logic [1:0] KIND_OTHER  = 2'd2;

  // Header decoding
  localparam logic [7:0] HDR_MASK    = 8'hFC;
  localparam logic [7:0] HDR_ACCEL   = 8'h84;
  localparam logic [7:0] HDR_SHORT_A = 8'h40;
  localparam logic [7:0] HDR_LONG    = 8'h44;
  localparam logic [7:0] HDR_SHORT_B = 8'h48;
  localparam logic [7:0] HDR_SHORT_C = 8'h50;

  // Payload lengths after the header byte
  localparam logic [2:0] LEN_ACCEL = 3'd6;
  localparam logic [2:0] LEN_SHORT = 3'd1;
  localparam logic [2:0] LEN_LONG  = 3'd3;

  localparam int MAX_SAMPLES_DEF = 32;
  localparam int IDX_W = 5;
  localparam int SHIFT_W = 40;
  localparam int OUT_TDATA_W = 56;

  typedef logic signed [15:0] axis_t;

  // Negate with saturation: the most negative value maps to the most positive
  function automatic axis_t neg_sat(input axis_t v);
    axis_t r;
    if (v == 16'sh8000) begin
      r = 16'sh7FFF;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

[rtl/accel_fifo_frame_parser_top.sv]
// Accelerometer FIFO frame parser, top level.
// Depends on afp_pkg and accel_fifo_frame_parser_top_defines.svh.
//
// Usage:
//   The slave channel takes one FIFO byte per transfer: s_tdata carries the
//   byte, s_tuser marks the first byte of a new FIFO read (burst start),
//   which drops any partial frame and restarts the sample index.
//   Frames are selected by the header byte with its two tag bits masked.
//   Each complete accel frame produces one transfer on the master channel
//   with x, negated y, negated z and the sample index in the burst; all
//   other frames and unknown header bytes produce nothing. Accel frames
//   past MAX_SAMPLES in one burst are parsed and dropped.
//   Throughput: one byte per cycle while s_tready is high, set by a
//   single pass of the frame counter and byte shifter between the parser
//   state and the result register. Latency: a result is valid the cycle
//   after its last byte. When the receiver stalls, the result register
//   holds and s_tready drops only while a result waits and m_tready is
//   low; a byte is still taken in the cycle the waiting result leaves.
//   Reset (rst, synchronous) clears the parser to expect a header, zeroes
//   the sample count and empties the result register.
`include "accel_fifo_frame_parser_top_defines.svh"

module accel_fifo_frame_parser_top #(
  parameter int MAX_SAMPLES = afp_pkg::MAX_SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // [7:0] data_byte
  input  logic                             s_tuser,  // [0] burst_start
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [52:48] sample_index,
  // [55:53] zero
  output logic [afp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import afp_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  // Parser state
  logic [1:0]         frame_kind, frame_kind_next;
  logic [2:0]         bytes_left, bytes_left_next;
  logic [SHIFT_W-1:0] payload_shift, payload_shift_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;

  // Result register
  logic               out_valid;
  axis_t              out_x, out_y, out_z;
  logic [IDX_W-1:0]   out_idx;

  logic               s_fire;
  logic               emit;
  logic [1:0]         kind_in;
  logic [2:0]         left_in;
  logic [CNT_W-1:0]   count_in;
  logic [CNT_W+IDX_W-1:0] count_ext;
  logic [7:0]         hdr;
  axis_t              raw_x, raw_y, raw_z;

  assign s_tready = !out_valid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  // Apply burst start before handling the byte
  assign kind_in  = s_tuser ? KIND_HEADER : frame_kind;
  assign left_in  = s_tuser ? 3'd0 : bytes_left;
  assign count_in = s_tuser ? '0 : sample_count;
  assign count_ext = {{IDX_W{1'b0}}, count_in};
  assign hdr = s_tdata & HDR_MASK;

  // Assemble the axes from the shifted payload and the final byte
  assign raw_x = payload_shift[15:0];
  assign raw_y = payload_shift[31:16];
  assign raw_z = {s_tdata, payload_shift[39:32]};

  // Advance the frame parser by one byte
  always_comb begin
    frame_kind_next    = frame_kind;
    bytes_left_next    = bytes_left;
    payload_shift_next = payload_shift;
    sample_count_next  = sample_count;
    emit               = 1'b0;
    if (s_fire) begin
      sample_count_next = count_in;
      unique case (kind_in)
        KIND_OTHER: begin
          bytes_left_next = left_in - 3'd1;
          frame_kind_next = (left_in == 3'd1) ? KIND_HEADER : KIND_OTHER;
        end
        KIND_ACCEL: begin
          if (left_in > 3'd1) begin
            payload_shift_next = {s_tdata, payload_shift[SHIFT_W-1:8]};
            bytes_left_next    = left_in - 3'd1;
          end else begin
            frame_kind_next = KIND_HEADER;
            bytes_left_next = 3'd0;
            if (count_in < CNT_MAX) begin
              emit              = 1'b1;
              sample_count_next = count_in + CNT_W'(1);
            end
          end
        end
        default: begin
          frame_kind_next = KIND_HEADER;
          bytes_left_next = 3'd0;
          case (hdr) inside
            HDR_ACCEL: begin
              frame_kind_next = KIND_ACCEL;
              bytes_left_next = LEN_ACCEL;
            end
            HDR_SHORT_A, HDR_SHORT_B, HDR_SHORT_C: begin
              frame_kind_next = KIND_OTHER;
              bytes_left_next = LEN_SHORT;
            end
            HDR_LONG: begin
              frame_kind_next = KIND_OTHER;
              bytes_left_next = LEN_LONG;
            end
            default: begin
              frame_kind_next = KIND_HEADER;
            end
          endcase
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind   <= KIND_HEADER;
      bytes_left   <= 3'd0;
      sample_count <= '0;
    end else begin
      frame_kind   <= frame_kind_next;
      bytes_left   <= bytes_left_next;
      sample_count <= sample_count_next;
    end
  end

  always_ff @(posedge clk) begin
    payload_shift <= payload_shift_next;
  end

  // Load the result register on a finished frame, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && emit) begin
      out_x   <= raw_x;
      out_y   <= neg_sat(raw_y);
      out_z   <= neg_sat(raw_z);
      out_idx <= count_ext[IDX_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_idx, out_z, out_y, out_x};

  // Checks
  `AFP_ASSERT(a_left_nonzero, clk, rst, (frame_kind != KIND_HEADER) |-> (bytes_left != 3'd0), "payload state with no bytes left")
  `AFP_ASSERT(a_accel_len, clk, rst, (frame_kind == KIND_ACCEL) |-> (bytes_left <= LEN_ACCEL), "accel frame length out of range")
  `AFP_ASSERT(a_result_source, clk, rst, $rose(m_tvalid) |-> $past(s_fire && emit), "result appeared without a finished frame")
  `AFP_ASSERT_ALWAYS(a_count_cap, clk, (rst || (sample_count <= CNT_MAX)), "sample count above its limit")

endmodule
